// File: hw/rtl/priority_active_expired_scheduler_core_macros.svh
// Assertion macros for the priority scheduler core.
// Used by the top level; needs no other file.
`ifndef PRIORITY_ACTIVE_EXPIRED_SCHEDULER_CORE_MACROS_SVH
`define PRIORITY_ACTIVE_EXPIRED_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PAES_AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, checked outside reset.
`define PAES_AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// File: hw/rtl/paes_pkg.sv
// Shared types and constants for the priority scheduler core.
// No dependencies.
`timescale 1ns / 1ps

package paes_pkg;

    typedef enum logic {
        REQ_ADD  = 1'b0,
        REQ_POLL = 1'b1
    } t_req_kind;

    typedef enum logic [2:0] {
        ST_ADD_ACTIVE  = 3'd0,
        ST_ADD_EXPIRED = 3'd1,
        ST_DISPATCHED  = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_FULL        = 3'd4,
        ST_BAD_LEVEL   = 3'd5
    } t_status;

    localparam logic signed [6:0] DYN_EXPIRED    = -7'sd1;
    localparam logic [6:0]        NUM_LEVELS_RST = 7'd4;

    typedef struct packed {
        t_req_kind          req_type;
        logic [7:0]         process_id;
        logic signed [6:0]  dyn_prio;
        logic [5:0]         reset_prio;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [5:0]  level;
        logic        swapped;
    } t_res;

endpackage

// File: hw/rtl/paes_store.sv
// Handle store: single-port RAM, one write or one read per cycle, registered read.
// No dependencies.
`timescale 1ns / 1ps

module paes_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/paes_sched.sv
// Queue bookkeeping: per-FIFO counts and heads, active bank, add/poll decision.
// Depends on paes_pkg; drives the store port of paes_store.
`timescale 1ns / 1ps

module paes_sched
    import paes_pkg::*;
#(
    parameter int MAX_LEVELS  = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int AW          = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  t_req          i_req,
    input  logic [6:0]    i_num_levels,
    output t_res          o_res,
    output logic          o_wr_en,
    output logic          o_rd_en,
    output logic [AW-1:0] o_addr,
    output logic [7:0]    o_wdata
);

    localparam int NF = 2 * MAX_LEVELS;
    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int FW = $clog2(NF);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [6:0]    MAX_LV  = 7'(MAX_LEVELS);
    localparam logic [CW-1:0] FULL_CT = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PT = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(QUEUE_DEPTH);

    logic [CW-1:0] r_cnt  [NF];
    logic [PW-1:0] r_head [NF];
    logic          r_active;

    logic [6:0]          eff;
    logic                expired;
    logic [5:0]          tgt;
    logic                bad;
    logic                full;
    logic [FW-1:0]       add_f;
    logic [CW:0]         slot_sum;
    logic [PW-1:0]       slot;
    logic [MAX_LEVELS-1:0] occ_a, occ_x;
    logic                hit_a, hit_x;
    logic [LW-1:0]       lvl_a, lvl_x, sel_lvl;
    logic                sel_bank;
    logic [FW-1:0]       poll_f;
    logic                do_add, do_poll;

    assign eff = (i_num_levels < MAX_LV) ? i_num_levels : MAX_LV;

    // Add path: target level, bank and free slot.
    always_comb begin
        expired  = (i_req.dyn_prio == DYN_EXPIRED);
        tgt      = expired ? i_req.reset_prio : i_req.dyn_prio[5:0];
        bad      = (i_req.dyn_prio[6] && !expired) || ({1'b0, tgt} >= eff);
        add_f    = (r_active ^ expired) ? FW'(MAX_LEVELS) + FW'(tgt[LW-1:0])
                                        : FW'(tgt[LW-1:0]);
        full     = (r_cnt[add_f] == FULL_CT);
        slot_sum = (CW + 1)'(r_head[add_f]) + (CW + 1)'(r_cnt[add_f]);
        slot     = (slot_sum >= DEPTH_W) ? PW'(slot_sum - DEPTH_W) : PW'(slot_sum);
    end

    // Poll path: highest occupied visible level in each bank.
    always_comb begin
        occ_a = '0;
        occ_x = '0;
        lvl_a = '0;
        lvl_x = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            occ_a[l] = (7'(l) < eff) &&
                       (r_cnt[r_active ? FW'(MAX_LEVELS + l) : FW'(l)] != '0);
            occ_x[l] = (7'(l) < eff) &&
                       (r_cnt[r_active ? FW'(l) : FW'(MAX_LEVELS + l)] != '0);
            if (occ_a[l]) begin
                lvl_a = LW'(l);
            end
            if (occ_x[l]) begin
                lvl_x = LW'(l);
            end
        end
        hit_a    = |occ_a;
        hit_x    = |occ_x;
        sel_bank = hit_a ? r_active : !r_active;
        sel_lvl  = hit_a ? lvl_a : lvl_x;
        poll_f   = sel_bank ? FW'(MAX_LEVELS) + FW'(sel_lvl) : FW'(sel_lvl);
    end

    always_comb begin
        o_res.status  = ST_EMPTY;
        o_res.level   = '0;
        o_res.swapped = 1'b0;
        o_addr        = '0;
        o_wdata       = i_req.process_id;
        do_add        = 1'b0;
        do_poll       = 1'b0;
        if (i_req.req_type == REQ_ADD) begin
            o_addr = AW'(add_f) * AW'(QUEUE_DEPTH) + AW'(slot);
            if (bad) begin
                o_res.status = ST_BAD_LEVEL;
            end else if (full) begin
                o_res.status = ST_FULL;
                o_res.level  = tgt;
            end else begin
                o_res.status = expired ? ST_ADD_EXPIRED : ST_ADD_ACTIVE;
                o_res.level  = tgt;
                do_add       = 1'b1;
            end
        end else begin
            o_addr        = AW'(poll_f) * AW'(QUEUE_DEPTH) + AW'(r_head[poll_f]);
            o_res.swapped = !hit_a;
            if (hit_a || hit_x) begin
                o_res.status = ST_DISPATCHED;
                o_res.level  = 6'(sel_lvl);
                do_poll      = 1'b1;
            end
        end
    end

    assign o_wr_en = i_fire && do_add;
    assign o_rd_en = i_fire && do_poll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            for (int f = 0; f < NF; f++) begin
                r_cnt[f]  <= '0;
                r_head[f] <= '0;
            end
        end else if (i_fire) begin
            if (do_add) begin
                r_cnt[add_f] <= r_cnt[add_f] + CW'(1);
            end
            if (i_req.req_type == REQ_POLL && !hit_a) begin
                r_active <= !r_active;
            end
            if (do_poll) begin
                r_cnt[poll_f]  <= r_cnt[poll_f] - CW'(1);
                r_head[poll_f] <= (r_head[poll_f] == LAST_PT) ? '0
                                                              : r_head[poll_f] + PW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/priority_active_expired_scheduler_core.sv
// Priority scheduler with active and expired banks: top level.
// Depends on paes_pkg, paes_sched, paes_store and the assertion macro header.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser: req_type; tdata: request
//  m_axis    out        m_axis_tvalid / m_axis_tready   tuser: status; tdata: grant
//  cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_data: num_levels
//
//  One request per cycle sustained while m_axis is not stalled; a result goes through the
//  request register, then bookkeeping plus store access into the result register, before
//  it is offered on m_axis.
//  The store has one port, used by each request for at most one write or one read.
//  Reset clears counts, heads and the active bank; store contents are not cleared.
//  A stall on m_axis holds the result register and backs up into s_axis.

module priority_active_expired_scheduler_core
    import paes_pkg::*;
#(
    parameter int MAX_LEVELS  = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // process_id[7:0], dyn_prio[14:8], reset_prio[20:15]
    input  logic [0:0]  s_axis_tuser,   // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // granted_id[7:0], granted_level[13:8], banks_swapped[14]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

`include "priority_active_expired_scheduler_core_macros.svh"

    localparam int STORE_DEPTH = 2 * MAX_LEVELS * QUEUE_DEPTH;
    localparam int AW          = $clog2(STORE_DEPTH);

    logic          r_in_vld;
    t_req          r_req;
    logic          r_out_vld;
    t_res          r_res;
    logic [6:0]    r_num_levels;

    logic          fire;
    t_res          res;
    logic          wr_en, rd_en;
    logic [AW-1:0] addr;
    logic [7:0]    wdata, rdata;

    assign fire          = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || fire;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_num_levels <= NUM_LEVELS_RST;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_num_levels <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req.req_type   <= t_req_kind'(s_axis_tuser[0]);
            r_req.process_id <= s_axis_tdata[7:0];
            r_req.dyn_prio   <= s_axis_tdata[14:8];
            r_req.reset_prio <= s_axis_tdata[20:15];
        end
        if (fire) begin
            r_res <= res;
        end
    end

    paes_sched #(
        .MAX_LEVELS  (MAX_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_req        (r_req),
        .i_num_levels (r_num_levels),
        .o_res        (res),
        .o_wr_en      (wr_en),
        .o_rd_en      (rd_en),
        .o_addr       (addr),
        .o_wdata      (wdata)
    );

    paes_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr_en (wr_en),
        .i_rd_en (rd_en),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    // Handle comes straight from the store's read register.
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tdata  = {1'b0, r_res.swapped, r_res.level,
                            (r_res.status == ST_DISPATCHED) ? rdata : 8'd0};

    `PAES_AST_IMP(a_one_store_op, i_clk, i_rst_n, wr_en, !rd_en)
    `PAES_AST_IMP(a_store_op_on_fire, i_clk, i_rst_n, wr_en || rd_en, fire)
    `PAES_AST_IMP(a_swap_only_on_poll, i_clk, i_rst_n, r_out_vld && r_res.swapped,
                  r_res.status == ST_DISPATCHED || r_res.status == ST_EMPTY)
    `PAES_AST_NXT(a_fire_gives_result, i_clk, i_rst_n, fire, r_out_vld)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for priority_active_expired_scheduler_core: directed table, then random
// phases under several num_levels settings. Needs paes_pkg and the core RTL.

module tb;
    import paes_pkg::*;

    localparam int MAX_LEVELS     = 4;
    localparam int QUEUE_DEPTH    = 16;
    localparam int FIFO_COUNT     = 2 * MAX_LEVELS;
    localparam int PHASES         = 7;
    localparam int RAND_PER_PHASE = 250;
    localparam int BURST_LEN      = 40;
    localparam int STALL_CYCLES   = 300;
    localparam int MAX_REPORTS    = 10;
    localparam logic [6:0] PHASE_LEVELS [PHASES] =
        '{7'd127, 7'd1, 7'd0, 7'd64, 7'd2, 7'd3, 7'd4};

    typedef struct packed {
        t_status    status;
        logic [7:0] id;
        logic [5:0] level;
        logic       swapped;
    } t_grant;

    typedef struct {
        t_req   req;
        bit     typed;
        t_grant want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;

    bit steady;
    bit stall_req;
    int mismatches = 0;

    // ready-queue model: one FIFO per bank and level
    logic [7:0]  ready_ids [FIFO_COUNT][QUEUE_DEPTH];
    int unsigned head_slot [FIFO_COUNT];
    int unsigned held      [FIFO_COUNT];
    bit          live_bank;
    logic [6:0]  levels_cfg;
    t_grant      pending_grants [$];

    priority_active_expired_scheduler_core #(
        .MAX_LEVELS (MAX_LEVELS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned levels_in_use();
        return (levels_cfg < MAX_LEVELS) ? levels_cfg : MAX_LEVELS;
    endfunction

    // head of the highest non-empty level in the live bank
    function automatic bit pop_highest(output logic [7:0] id, output logic [5:0] lvl);
        int f;
        id  = 8'd0;
        lvl = 6'd0;
        for (int l = int'(levels_in_use()) - 1; l >= 0; l--) begin
            f = int'(live_bank) * MAX_LEVELS + l;
            if (held[f] != 0) begin
                id           = ready_ids[f][head_slot[f]];
                head_slot[f] = (head_slot[f] + 1) % QUEUE_DEPTH;
                held[f]--;
                lvl = 6'(l);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_grant schedule_req(input t_req r);
        t_grant g;
        int     tgt;
        int     f;
        bit     expired;
        g = '{status: ST_EMPTY, id: 8'd0, level: 6'd0, swapped: 1'b0};
        if (r.req_type == REQ_ADD) begin
            expired = (r.dyn_prio == DYN_EXPIRED);
            tgt = expired ? int'(r.reset_prio) : int'($signed(r.dyn_prio));
            if (tgt < 0 || tgt >= int'(levels_in_use())) begin
                g.status = ST_BAD_LEVEL;
            end else begin
                // expired handles go to the bank that is not live
                f = int'(live_bank ^ expired) * MAX_LEVELS + tgt;
                g.level = 6'(tgt);
                if (held[f] >= QUEUE_DEPTH) begin
                    g.status = ST_FULL;
                end else begin
                    ready_ids[f][(head_slot[f] + held[f]) % QUEUE_DEPTH] = r.process_id;
                    held[f]++;
                    g.status = expired ? ST_ADD_EXPIRED : ST_ADD_ACTIVE;
                end
            end
        end else begin
            if (pop_highest(g.id, g.level)) begin
                g.status = ST_DISPATCHED;
            end else begin
                live_bank = ~live_bank;
                g.swapped = 1'b1;
                if (pop_highest(g.id, g.level)) begin
                    g.status = ST_DISPATCHED;
                end else begin
                    g.status = ST_EMPTY;
                    g.id     = 8'd0;
                    g.level  = 6'd0;
                end
            end
        end
        return g;
    endfunction

    function automatic t_req random_req(input int poll_pct);
        t_req r;
        int   n;
        int   pick;
        n            = int'(levels_in_use());
        r.process_id = 8'($urandom);
        r.dyn_prio   = 7'($urandom);
        r.reset_prio = 6'($urandom);
        if ($urandom_range(0, 99) < poll_pct) begin
            r.req_type = REQ_POLL;
            return r;
        end
        r.req_type = REQ_ADD;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            r.dyn_prio = 7'($urandom_range(0, n > 0 ? n - 1 : MAX_LEVELS - 1));
        end else if (pick < 88) begin
            r.dyn_prio = DYN_EXPIRED;
            if (pick < 84)
                r.reset_prio = 6'($urandom_range(0, n > 0 ? n - 1 : MAX_LEVELS - 1));
        end
        return r;
    endfunction

    function automatic t_dir_row dir_row(input t_req_kind k, input logic [7:0] id,
                                         input logic [6:0] prio, input logic [5:0] rprio,
                                         input bit typed, input t_status st,
                                         input logic [5:0] lvl, input logic sw);
        t_dir_row row;
        row.req   = '{req_type: k, process_id: id, dyn_prio: prio, reset_prio: rprio};
        row.typed = typed;
        row.want  = '{status: st, id: 8'd0, level: lvl, swapped: sw};
        return row;
    endfunction

    task automatic offer_req(input t_req r, input bit typed, input t_grant want);
        t_grant g;
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req_type;
        s_axis_tdata  <= {3'b000, r.reset_prio, r.dyn_prio, r.process_id};
        do @(posedge i_clk); while (!s_axis_tready);
        g = schedule_req(r);
        pending_grants = {pending_grants, typed ? want : g};
    endtask

    // drop valid and wait out every outstanding result plus pipeline slack
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_levels(input logic [6:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        levels_cfg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result sink: random back-pressure, one long hold-off on request
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_req) begin
                stall_req  = 1'b0;
                stall_left = STALL_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant got;
        t_grant exp_g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tdata[14]};
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: unexpected result status %0d id %0d level %0d swapped %0d",
                             got.status, got.id, got.level, got.swapped);
            end else begin
                exp_g = pending_grants.pop_front();
                if (got.status !== exp_g.status || got.id !== exp_g.id ||
                    got.level !== exp_g.level || got.swapped !== exp_g.swapped) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"tb: mismatch exp st %0d id %0d lvl %0d sw %0d,",
                                  " got st %0d id %0d lvl %0d sw %0d"},
                                 exp_g.status, exp_g.id, exp_g.level, exp_g.swapped,
                                 got.status, got.id, got.level, got.swapped);
                end
            end
        end
    end

    initial begin
        t_dir_row rows [$];
        int       burst_poll;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        steady        = 1'b0;
        stall_req     = 1'b0;
        burst_poll    = 45;
        levels_cfg    = NUM_LEVELS_RST;
        live_bank     = 1'b0;
        for (int f = 0; f < FIFO_COUNT; f++) begin
            head_slot[f] = 0;
            held[f]      = 0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty poll right after reset still swaps the banks
        rows = {rows, dir_row(REQ_POLL, 8'h00, 7'h00, 6'h00, 1, ST_EMPTY, 6'd0, 1'b1)};
        rows = {rows, dir_row(REQ_ADD, 8'hFF, 7'sd3, 6'h00, 1, ST_ADD_ACTIVE, 6'd3, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'h00, 7'sd0, 6'h3F, 1, ST_ADD_ACTIVE, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'hA5, DYN_EXPIRED, 6'd2, 1, ST_ADD_EXPIRED, 6'd2, 1'b0)};
        // bad levels: out of range, most negative, below expired marker, bad reset level
        rows = {rows, dir_row(REQ_ADD, 8'h5A, 7'sd4, 6'h00, 1, ST_BAD_LEVEL, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'h3C, 7'sd63, 6'h00, 1, ST_BAD_LEVEL, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'hC3, 7'h40, 6'h00, 1, ST_BAD_LEVEL, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'h11, -7'sd2, 6'h01, 1, ST_BAD_LEVEL, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'h22, DYN_EXPIRED, 6'd63, 1, ST_BAD_LEVEL, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'h33, DYN_EXPIRED, 6'd4, 1, ST_BAD_LEVEL, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'h44, 7'sd3, 6'h00, 0, ST_EMPTY, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_POLL, 8'h00, 7'h00, 6'h00, 0, ST_EMPTY, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_POLL, 8'h00, 7'h00, 6'h00, 0, ST_EMPTY, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_POLL, 8'h00, 7'h00, 6'h00, 0, ST_EMPTY, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_POLL, 8'h00, 7'h00, 6'h00, 0, ST_EMPTY, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_POLL, 8'h00, 7'h00, 6'h00, 1, ST_EMPTY, 6'd0, 1'b1)};
        rows = {rows, dir_row(REQ_ADD, 8'h77, DYN_EXPIRED, 6'd0, 0, ST_EMPTY, 6'd0, 1'b0)};
        // poll fields are don't-care; send all ones
        rows = {rows, dir_row(REQ_POLL, 8'hFF, 7'h7F, 6'h3F, 0, ST_EMPTY, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'h80, 7'sd1, 6'h3F, 0, ST_EMPTY, 6'd0, 1'b0)};
        rows = {rows, dir_row(REQ_ADD, 8'h01, 7'sd2, 6'h00, 0, ST_EMPTY, 6'd0, 1'b0)};
        foreach (rows[i])
            offer_req(rows[i].req, rows[i].typed, rows[i].want);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_levels(PHASE_LEVELS[p]);
            steady = (p == 4);
            if (p == 3)
                stall_req = 1'b1;
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                // bursts: fill levels toward full, drain across swaps, or mix
                if (k % BURST_LEN == 0) begin
                    case ($urandom_range(0, 2))
                        0:       burst_poll = 5;
                        1:       burst_poll = 85;
                        default: burst_poll = 45;
                    endcase
                end
                offer_req(random_req(burst_poll), 1'b0, '0);
            end
        end
        steady = 1'b0;
        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_grants.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

// File: priority_active_expired_scheduler_core.f
+incdir+hw/rtl
hw/rtl/paes_pkg.sv
hw/rtl/paes_store.sv
hw/rtl/paes_sched.sv
hw/rtl/priority_active_expired_scheduler_core.sv
tb/tb.sv
